// ----- rtl/core/utf8s_pkg.sv -----
`timescale 1ns / 1ps

package utf8s_pkg;

  localparam logic [7:0] CTRL_LIMIT   = 8'h20;
  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] LEAD_ED  = 8'hED;

  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_E0_LO = 8'hA0;
  localparam logic [7:0] CONT_ED_HI = 8'h9F;
  localparam logic [7:0] CONT_F0_LO = 8'h90;
  localparam logic [7:0] CONT_F4_HI = 8'h8F;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [1:0] PHASE_B0 = 2'd0;
  localparam logic [1:0] PHASE_B1 = 2'd1;
  localparam logic [1:0] PHASE_B2 = 2'd2;

  localparam int unsigned TAIL_DEPTH = 4;
  localparam int unsigned MAX_REPL   = 4;

  // One decoded input item: replacements first, then up to four tail bytes.
  typedef struct packed {
    logic [2:0]      rep;
    logic [2:0]      tail_len;
    logic [3:0][7:0] tail;
    logic            replaced;
    logic            escaped;
  } run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return CHAR_ZERO + {4'd0, v};
    end else begin
      return CHAR_UPPER_A + {4'd0, v} - 8'd10;
    end
  endfunction

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      return 3'd2;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      return 3'd3;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      return 3'd4;
    end else begin
      return 3'd0;
    end
  endfunction

endpackage

// ----- rtl/core/utf8s_in_if.sv -----
`timescale 1ns / 1ps

interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ----- rtl/core/utf8s_out_if.sv -----
`timescale 1ns / 1ps

interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       replaced_seen;
  logic       escaped_seen;

  modport source (output valid, output out_byte, output last_of_run,
                  output replaced_seen, output escaped_seen, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input replaced_seen, input escaped_seen, output ready);
endinterface

// ----- rtl/core/utf8s_decode.sv -----
`timescale 1ns / 1ps

module utf8s_decode
  import utf8s_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       end_of_stream,
  output run_t       run,
  output logic       run_valid
);

  logic [7:0]      lead_byte, lead_byte_next;
  logic [1:0]      held_count, held_count_next;
  logic [2:0]      expected_length, expected_length_next;
  logic [1:0][7:0] held_cont, held_cont_next;
  logic            replaced_flag, replaced_flag_next;
  logic            escaped_flag, escaped_flag_next;

  logic       held;
  logic       cont_ok;
  logic       fresh;
  logic       esc;
  logic [7:0] lo, hi;
  logic [2:0] len;

  assign held = (expected_length != 3'd0);
  assign len  = lead_length(in_byte);

  always_comb begin
    lo = CONT_LO;
    hi = CONT_HI;
    if (held_count == 2'd0) begin
      if (lead_byte == LEAD3_LO) begin
        lo = CONT_E0_LO;
      end else if (lead_byte == LEAD_ED) begin
        hi = CONT_ED_HI;
      end else if (lead_byte == LEAD4_LO) begin
        lo = CONT_F0_LO;
      end else if (lead_byte == LEAD4_HI) begin
        hi = CONT_F4_HI;
      end
    end
    cont_ok = (in_byte >= lo) && (in_byte <= hi);
  end

  always_comb begin
    lead_byte_next       = lead_byte;
    held_count_next      = held_count;
    expected_length_next = expected_length;
    held_cont_next       = held_cont;
    run                  = '0;
    fresh                = 1'b0;
    esc                  = 1'b0;

    if (end_of_stream) begin
      if (held) begin
        run.rep              = {1'b0, held_count} + 3'd1;
        lead_byte_next       = '0;
        held_count_next      = '0;
        expected_length_next = '0;
        held_cont_next       = '0;
      end
    end else if (held && cont_ok) begin
      if ({1'b0, held_count} + 3'd2 >= expected_length) begin
        run.tail[0] = lead_byte;
        run.tail[1] = held_cont[0];
        run.tail[2] = held_cont[1];
        run.tail[held_count + 2'd1] = in_byte;
        run.tail_len         = {1'b0, held_count} + 3'd2;
        lead_byte_next       = '0;
        held_count_next      = '0;
        expected_length_next = '0;
        held_cont_next       = '0;
      end else begin
        held_cont_next[held_count[0]] = in_byte;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      fresh = 1'b1;
      if (held) begin
        run.rep              = {1'b0, held_count} + 3'd1;
        lead_byte_next       = '0;
        held_count_next      = '0;
        expected_length_next = '0;
        held_cont_next       = '0;
      end
    end

    if (fresh) begin
      if (in_byte < ASCII_LIMIT) begin
        if (in_byte < CTRL_LIMIT && in_byte != CHAR_TAB && in_byte != CHAR_LF &&
            in_byte != CHAR_CR) begin
          run.tail[0]  = CHAR_BSLASH;
          run.tail[1]  = CHAR_X;
          run.tail[2]  = hex_digit(in_byte[7:4]);
          run.tail[3]  = hex_digit(in_byte[3:0]);
          run.tail_len = 3'd4;
          esc          = 1'b1;
        end else begin
          run.tail[0]  = in_byte;
          run.tail_len = 3'd1;
        end
      end else if (len != 3'd0) begin
        lead_byte_next       = in_byte;
        held_count_next      = '0;
        expected_length_next = len;
      end else begin
        run.rep = run.rep + 3'd1;
      end
    end

    run.replaced       = replaced_flag | (run.rep != 3'd0);
    run.escaped        = escaped_flag | esc;
    replaced_flag_next = end_of_stream ? 1'b0 : run.replaced;
    escaped_flag_next  = end_of_stream ? 1'b0 : run.escaped;
  end

  assign run_valid = (run.rep != 3'd0) || (run.tail_len != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte       <= '0;
      held_count      <= '0;
      expected_length <= '0;
      held_cont       <= '0;
      replaced_flag   <= 1'b0;
      escaped_flag    <= 1'b0;
    end else if (take) begin
      lead_byte       <= lead_byte_next;
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
      held_cont       <= held_cont_next;
      replaced_flag   <= replaced_flag_next;
      escaped_flag    <= escaped_flag_next;
    end
  end

  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    held |-> ({1'b0, held_count} + 3'd1 < expected_length) && (expected_length <= 3'd4))
    else $error("held continuation count exceeds sequence length");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !held |-> (held_count == 2'd0) && (lead_byte == 8'd0))
    else $error("hold state not cleared");

  a_eos_flags: assert property (@(posedge clk) disable iff (rst)
    take && end_of_stream |=> !replaced_flag && !escaped_flag && !held)
    else $error("end of stream did not clear state");

endmodule

// ----- rtl/core/utf8s_serialize.sv -----
`timescale 1ns / 1ps

module utf8s_serialize
  import utf8s_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  run_t  run,
  output logic  slot_free,
  utf8s_out_if.source dst
);

  run_t       nxt;
  logic       nxt_valid;
  run_t       cur;
  logic       cur_valid;
  logic [2:0] rep_left;
  logic [1:0] phase;
  logic [1:0] tail_idx;

  logic is_last;
  logic cur_done;
  logic nxt_move;

  always_comb begin
    if (rep_left != 3'd0) begin
      is_last = (rep_left == 3'd1) && (phase == PHASE_B2) && (cur.tail_len == 3'd0);
    end else begin
      is_last = ({1'b0, tail_idx} + 3'd1 == cur.tail_len);
    end
  end

  always_comb begin
    if (rep_left != 3'd0) begin
      unique case (phase)
        PHASE_B0: dst.out_byte = REPL_B0;
        PHASE_B1: dst.out_byte = REPL_B1;
        PHASE_B2: dst.out_byte = REPL_B2;
        default:  dst.out_byte = REPL_B2;
      endcase
    end else begin
      dst.out_byte = cur.tail[tail_idx];
    end
  end

  assign dst.valid         = cur_valid;
  assign dst.last_of_run   = is_last;
  assign dst.replaced_seen = cur.replaced;
  assign dst.escaped_seen  = cur.escaped;

  assign cur_done  = cur_valid && dst.ready && is_last;
  assign nxt_move  = nxt_valid && (!cur_valid || cur_done);
  assign slot_free = !nxt_valid || nxt_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt_valid <= 1'b0;
    end else if (load) begin
      nxt_valid <= 1'b1;
    end else if (nxt_move) begin
      nxt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nxt <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rep_left  <= '0;
      phase     <= PHASE_B0;
      tail_idx  <= '0;
    end else if (nxt_move) begin
      cur_valid <= 1'b1;
      rep_left  <= nxt.rep;
      phase     <= PHASE_B0;
      tail_idx  <= '0;
    end else if (cur_done) begin
      cur_valid <= 1'b0;
    end else if (cur_valid && dst.ready) begin
      if (rep_left != 3'd0) begin
        if (phase == PHASE_B2) begin
          phase    <= PHASE_B0;
          rep_left <= rep_left - 3'd1;
        end else begin
          phase <= phase + 2'd1;
        end
      end else begin
        tail_idx <= tail_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_move) begin
      cur <= nxt;
    end
  end

  a_tail_exists: assert property (@(posedge clk) disable iff (rst)
    cur_valid && rep_left == 3'd0 |-> {1'b0, tail_idx} < cur.tail_len)
    else $error("serializer points past the end of the run");

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    nxt_valid |-> (nxt.rep != 3'd0 || nxt.tail_len != 3'd0) &&
                  nxt.rep <= 3'(MAX_REPL) && nxt.tail_len <= 3'(TAIL_DEPTH))
    else $error("queued run is empty or oversized");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> slot_free)
    else $error("run loaded while the slot is taken");

  a_cur_refill: assert property (@(posedge clk) disable iff (rst)
    nxt_valid && !cur_valid |=> cur_valid)
    else $error("queued run did not move to the output");

endmodule

// ----- rtl/core/utf8s_top_check.sv -----
`timescale 1ns / 1ps

module utf8s_top_check (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       replaced_seen,
  input logic       escaped_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output item changed");

  a_flags_in_run: assert property (@(posedge clk) disable iff (rst)
    $past(valid && ready && !last_of_run) && valid |->
      replaced_seen == $past(replaced_seen) &&
      escaped_seen == $past(escaped_seen))
    else $error("flags changed inside one run");

  a_out_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(valid) &&
    (!valid || !$isunknown({out_byte, last_of_run, replaced_seen, escaped_seen})))
    else $error("output item has unknown bits");

endmodule

// ----- rtl/core/utf8_sanitizer_core.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Payload                                            Handshake
// src      sink       in_byte[7:0], end_of_stream                        valid/ready
// dst      source     out_byte[7:0], last_of_run, replaced_seen,         valid/ready
//                     escaped_seen
//
// One input item is decoded in the cycle it is accepted; its run goes to the queued slot,
// then the current slot; bytes follow one per cycle while dst is ready, 0 to 13 per item.
// Input throughput is one item per cycle while items yield at most one byte and dst is ready.
// A two-entry run buffer lets a new item in while the previous run still drains.
// Reset is synchronous and clears the held sequence, the flags and both run slots.
// A stall on the output holds the current byte and stops input once both slots are full.

module utf8_sanitizer_core
  import utf8s_pkg::*;
(
  input logic clk,
  input logic rst,
  utf8s_in_if.sink    src,
  utf8s_out_if.source dst
);

  run_t run;
  logic run_valid;
  logic slot_free;
  logic take;

  assign src.ready = slot_free;
  assign take      = src.valid && slot_free;

  utf8s_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .in_byte       (src.in_byte),
    .end_of_stream (src.end_of_stream),
    .run           (run),
    .run_valid     (run_valid)
  );

  utf8s_serialize u_serialize (
    .clk       (clk),
    .rst       (rst),
    .load      (take && run_valid),
    .run       (run),
    .slot_free (slot_free),
    .dst       (dst)
  );

  utf8s_top_check u_check (
    .clk           (clk),
    .rst           (rst),
    .valid         (dst.valid),
    .ready         (dst.ready),
    .out_byte      (dst.out_byte),
    .last_of_run   (dst.last_of_run),
    .replaced_seen (dst.replaced_seen),
    .escaped_seen  (dst.escaped_seen)
  );

endmodule
